// File: rtl/core/oaht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_pkg: shared types and constants
// Widths, status codes, slot state codes and the sequencer state type.
// ----------------------------------------------------------------------------
package oaht_pkg;

    localparam int SLOT_CAPACITY = 1024;
    localparam int SLOT_W        = $clog2(SLOT_CAPACITY);
    localparam int KEY_W         = 31;
    localparam int KIND_W        = 2;
    localparam int STATUS_W      = 3;
    localparam int SIZE_W        = 10;
    localparam int HASH_W        = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 10'd11;

    // floor(x / 10) = (x * RECIP_10) >> DIV10_SHIFT for any 32-bit x
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;

    localparam logic [1:0] SLOT_EMPTY   = 2'd0;
    localparam logic [1:0] SLOT_LEGIT   = 2'd1;
    localparam logic [1:0] SLOT_DELETED = 2'd2;

    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LIMIT    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd6;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_DIGIT,
        S_MOD,
        S_READ,
        S_WAIT,
        S_CHECK,
        S_STEP,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

// File: rtl/core/oaht_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_ram: generic single-port RAM
// One write or read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// File: rtl/core/open_addressing_hash_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// open_addressing_hash_table_core: hash table with quadratic probing
// Find, insert and delete of positive keys in a slot memory.
// ----------------------------------------------------------------------------
// Input stream s_axis: tuser = kind, tdata = key. One transaction is one
// request. Output stream m_axis: tdata = {slot, status}, one result per
// request. The user must write table_size through cfg_we/cfg_wdata only
// while idle; the block itself does not enforce this. After reset the slot
// state memory is swept to empty, one slot per cycle over all SLOT_CAPACITY
// slots, and s_axis_tready stays low during it. A request is handled one at
// a time: a divide state and a digit state per decimal digit of the key
// (reciprocal multiply, then digit extract), up to 10 digits, then a
// bit-serial modulo over the hash bits, MSB first, on a shared
// compare/subtract unit, then probes of the slot memory (read address,
// registered read, compare) with a step state between probes. A zero key
// gives its result on the next cycle. The result sits in an output
// register; the next request is taken in the cycle after the result
// transaction at the earliest, so a stalled receiver simply holds the
// block.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_core
    import oaht_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [9:0]  cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // key[30:0], zero pad
    input  wire logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // status[2:0], slot[12:3], zero pad
);

    state_t state_reg, state_next;

    logic [SIZE_W-1:0]   size_cfg_reg;
    logic [SLOT_W:0]     size_reg;      // effective size, 1..SLOT_CAPACITY-1
    logic [KIND_W-1:0]   kind_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [KEY_W-1:0]    rest_reg, rest_next;
    logic [KEY_W-1:0]    quot_reg, quot_next;
    logic [KEY_W+31:0]   recip_prod;
    logic [KEY_W-1:0]    digit_full;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic [SLOT_W:0]     rem_reg, rem_next;
    logic [4:0]          bit_cnt_reg;
    logic [SLOT_W:0]     pos_reg, pos_next;
    logic [SLOT_W:0]     inc_reg, inc_next;
    logic [SLOT_W:0]     probe_cnt_reg;
    logic [SLOT_W:0]     clr_cnt_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic                hit;

    // effective size from the register
    logic [SLOT_W:0] size_eff;
    always_comb
    begin
        if (size_cfg_reg == '0)
            size_eff = (SLOT_W+1)'(1);
        else if ({1'b0, size_cfg_reg} > (SIZE_W+1)'(SLOT_CAPACITY))
            size_eff = (SLOT_W+1)'(SLOT_CAPACITY);
        else
            size_eff = (SLOT_W+1)'(size_cfg_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_cfg_reg <= SIZE_RESET;
        else if (cfg_we)
            size_cfg_reg <= cfg_wdata;
    end

    // memories
    logic              ram_we, key_we;
    logic [SLOT_W-1:0] ram_addr;
    logic [1:0]        st_wdata, st_rdata;
    logic [KEY_W-1:0]  key_rdata;

    oaht_ram #(.WIDTH(2), .DEPTH(SLOT_CAPACITY)) u_state_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(st_wdata), .rdata(st_rdata)
    );
    oaht_ram #(.WIDTH(KEY_W), .DEPTH(SLOT_CAPACITY)) u_key_ram (
        .clk(clk), .we(key_we), .addr(ram_addr), .wdata(key_reg), .rdata(key_rdata)
    );

    assign hit = (st_rdata == SLOT_EMPTY) || (key_rdata == key_reg);

    // divide by ten through a reciprocal multiply
    assign recip_prod = {32'b0, rest_reg} * {31'b0, RECIP_10};

    // shared subtract/compare unit: remainder step or probe wrap
    logic [SLOT_W+1:0] alu_a, alu_b, alu_diff;
    assign alu_diff = alu_a - alu_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_cnt_reg == (SLOT_W+1)'(SLOT_CAPACITY - 1)) state_next = S_IDLE;
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tdata[30:0] == '0) state_next = S_OUT;
                    else                          state_next = S_DIV;
                end
            end
            S_DIV:   state_next = S_DIGIT;
            S_DIGIT:
            begin
                if (rest_next == '0) state_next = S_MOD;
                else                 state_next = S_DIV;
            end
            S_MOD:   if (bit_cnt_reg == 5'd0) state_next = S_READ;
            S_READ:  state_next = S_WAIT;
            S_WAIT:  state_next = S_CHECK;
            S_CHECK:
            begin
                if (hit || probe_cnt_reg + 1'b1 == size_reg) state_next = S_OUT;
                else                                         state_next = S_STEP;
            end
            S_STEP:  state_next = S_READ;
            S_OUT:   if (m_axis_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        quot_next   = KEY_W'(recip_prod >> DIV10_SHIFT);
        // low digit: rest - 10 * quotient
        digit_full  = rest_reg - {quot_reg[KEY_W-4:0], 3'b000}
                               - {quot_reg[KEY_W-2:0], 1'b0};
        rest_next   = quot_reg;
        hash_next   = (hash_reg << 3) + HASH_W'(digit_full[3:0]);
        rem_next    = rem_reg;
        pos_next    = pos_reg;
        inc_next    = inc_reg;
        status_next = status_reg;
        alu_a       = '0;
        alu_b       = '0;
        ram_we      = 1'b0;
        key_we      = 1'b0;
        ram_addr    = pos_reg[SLOT_W-1:0];
        st_wdata    = SLOT_EMPTY;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_cnt_reg[SLOT_W-1:0];
            end
            S_MOD:
            begin
                alu_a = {rem_reg, hash_reg[bit_cnt_reg]};
                alu_b = {1'b0, size_reg};
                if (!alu_diff[SLOT_W+1]) rem_next = alu_diff[SLOT_W:0];
                else                     rem_next = alu_a[SLOT_W:0];
            end
            S_CHECK:
            begin
                if (hit)
                begin
                    if (kind_reg == KIND_INSERT)
                    begin
                        if (st_rdata == SLOT_LEGIT) status_next = ST_PRESENT;
                        else
                        begin
                            status_next = ST_INSERTED;
                            ram_we = 1'b1;
                            key_we = 1'b1;
                            st_wdata = SLOT_LEGIT;
                        end
                    end
                    else if (kind_reg == KIND_DELETE)
                    begin
                        if (st_rdata == SLOT_LEGIT)
                        begin
                            status_next = ST_REMOVED;
                            ram_we = 1'b1;
                            st_wdata = SLOT_DELETED;
                        end
                        else status_next = ST_ABSENT;
                    end
                    else
                        status_next = (st_rdata == SLOT_LEGIT) ? ST_FOUND : ST_ABSENT;
                end
                else
                begin
                    status_next = ST_LIMIT;
                    alu_a = {1'b0, pos_reg} + {1'b0, inc_reg};
                    alu_b = {1'b0, size_reg};
                    pos_next = alu_diff[SLOT_W+1] ? alu_a[SLOT_W:0] : alu_diff[SLOT_W:0];
                end
            end
            S_STEP:
            begin
                // inc + 2 wraps at most twice
                alu_a = {1'b0, inc_reg} + (SLOT_W+2)'(2);
                alu_b = {1'b0, size_reg};
                if (alu_diff[SLOT_W+1]) inc_next = alu_a[SLOT_W:0];
                else if (alu_diff[SLOT_W:0] >= size_reg)
                    inc_next = alu_diff[SLOT_W:0] - size_reg;
                else inc_next = alu_diff[SLOT_W:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                kind_reg    <= s_axis_tuser;
                key_reg     <= s_axis_tdata[30:0];
                rest_reg    <= s_axis_tdata[30:0];
                hash_reg    <= '0;
                size_reg    <= size_eff;
                status_reg  <= ST_ZERO;
                slot_reg    <= '0;
            end
            S_DIV:
            begin
                quot_reg    <= quot_next;
            end
            S_DIGIT:
            begin
                rest_reg    <= rest_next;
                hash_reg    <= hash_next;
                rem_reg     <= '0;
                bit_cnt_reg <= 5'd31;
            end
            S_MOD:
            begin
                rem_reg     <= rem_next;
                bit_cnt_reg <= bit_cnt_reg - 1'b1;
                pos_reg     <= rem_next;
                inc_reg     <= (size_reg == (SLOT_W+1)'(1)) ? '0 : (SLOT_W+1)'(1);
                probe_cnt_reg <= '0;
            end
            S_CHECK:
            begin
                status_reg <= status_next;
                slot_reg   <= pos_reg[SLOT_W-1:0];
                pos_reg    <= pos_next;
            end
            S_STEP:
            begin
                inc_reg       <= inc_next;
                probe_cnt_reg <= probe_cnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {3'b000, slot_reg, status_reg};

`ifndef SYNTHESIS
    // no request taken during the clearing sweep
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_axis_tready)
        else $error("request accepted during clear");
    // probe position stays inside the table
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (pos_reg < size_reg))
        else $error("probe position out of range");
    // a zero key yields ST_ZERO without hashing or probing
    a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata[30:0] == '0)
        |=> (m_axis_tvalid && m_axis_tdata[2:0] == ST_ZERO))
        else $error("zero key not flagged");
`endif

endmodule
`default_nettype wire

// File: dv/open_addressing_hash_table_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_table_core_test: self-checking bench for the hash core
// Drives find/insert/delete requests over the input stream, predicts status
// and slot for each one with a local table model, and compares every result
// transaction in order. Covers table sizes from 11 to 1021, full tables,
// lazy deletion, zero keys and back-pressure on both streams.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_core_test;
    import oaht_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [9:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    // predictor state
    logic [KEY_W-1:0] key_store [SLOT_CAPACITY];
    logic [1:0]       slot_state [SLOT_CAPACITY];
    int unsigned      active_size;
    outcome_t         pending_q [$];
    int               error_count;
    int               result_count;
    int               cycle_count;
    bit               idle_enable;
    bit               hold_receiver;
    int unsigned      live_keys [$];

    open_addressing_hash_table_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),  // key[30:0], zero pad
        .s_axis_tuser  (s_axis_tuser),  // kind[1:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)   // status[2:0], slot[12:3], zero pad
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("open_addressing_hash_table_core: mismatch");
            $finish;
        end
    end

    function automatic int unsigned home_slot(input int unsigned key, input int unsigned size);
        logic [31:0] h;
        int unsigned k;
        h = 0;
        k = key;
        while (k != 0)
        begin
            h = (h << 3) + (k % 10);
            k = k / 10;
        end
        return h % size;
    endfunction

    // table model: compute one request's outcome and update the table
    function automatic outcome_t lookup_and_update(input logic [1:0] kind,
                                                   input logic [KEY_W-1:0] key);
        outcome_t    res;
        int unsigned size;
        int unsigned pos;
        int unsigned inc;
        bit          stopped;
        res = '0;
        if (key == 0)
        begin
            res.status = ST_ZERO;
            return res;
        end
        size = (active_size == 0) ? 1 : (active_size > SLOT_CAPACITY ? SLOT_CAPACITY
                                                                      : active_size);
        pos = home_slot(key, size);
        inc = 1 % size;
        stopped = 0;
        for (int unsigned n = 0; n < size; n++)
        begin
            if (slot_state[pos] == SLOT_EMPTY || key_store[pos] == key)
            begin
                stopped = 1;
                break;
            end
            if (n + 1 == size)
                break;
            pos += inc;
            if (pos >= size) pos -= size;
            inc += 2;
            if (inc >= size) inc -= size;
            if (inc >= size) inc -= size;
        end
        res.slot = pos[SLOT_W-1:0];
        if (!stopped)
            res.status = ST_LIMIT;
        else if (kind == KIND_INSERT)
        begin
            if (slot_state[pos] == SLOT_LEGIT)
                res.status = ST_PRESENT;
            else
            begin
                slot_state[pos] = SLOT_LEGIT;
                key_store[pos] = key;
                res.status = ST_INSERTED;
            end
        end
        else if (kind == KIND_DELETE)
        begin
            if (slot_state[pos] == SLOT_LEGIT)
            begin
                slot_state[pos] = SLOT_DELETED;
                res.status = ST_REMOVED;
            end
            else
                res.status = ST_ABSENT;
        end
        else
            res.status = (slot_state[pos] == SLOT_LEGIT) ? ST_FOUND : ST_ABSENT;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("error: result %0d %s got %0d expected %0d", result_count, what, got, want);
        error_count++;
    endtask

    // send one request; prediction is made at acceptance. tvalid stays up
    // after acceptance until the next request or drain() takes it over.
    task automatic send_request(input logic [1:0] kind, input logic [KEY_W-1:0] key);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, key};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pending_q.push_back(lookup_and_update(kind, key));
        if (kind == KIND_INSERT) live_keys.push_back(key);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    // write table_size while idle; neither the model nor the slot memory is cleared
    task automatic set_table_size(input int unsigned size);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= size[9:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        active_size = size;
    endtask

    // result checker
    always @(posedge clk)
    begin
        outcome_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_q.size() == 0)
                report_mismatch("unexpected result", int'(m_axis_tdata), 0);
            else
            begin
                want = pending_q.pop_front();
                if (m_axis_tdata[2:0] !== want.status)
                    report_mismatch("status", m_axis_tdata[2:0], want.status);
                if (m_axis_tdata[12:3] !== want.slot)
                    report_mismatch("slot", m_axis_tdata[12:3], want.slot);
                if (m_axis_tdata[15:13] !== 3'b0)
                    report_mismatch("pad", m_axis_tdata[15:13], 0);
            end
            result_count++;
        end
    end

    // receiver stalls
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_receiver)
                m_axis_tready <= 1'b0;
            else if (idle_enable && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [KEY_W-1:0] random_key(input int unsigned span);
        if (span != 0 && live_keys.size() != 0 && $urandom_range(0, 1))
            return KEY_W'(live_keys[$urandom_range(0, live_keys.size() - 1)]);
        case ($urandom_range(0, 3))
            0: return KEY_W'($urandom_range(1, 200));
            1: return KEY_W'($urandom_range(1, 99999));
            2: return KEY_W'($urandom() & 32'h7FFF_FFFF);
            default: return KEY_W'(32'h7FFF_FFFF - $urandom_range(0, 15));
        endcase
    endfunction

    task automatic test_directed();
        send_request(KIND_FIND, 31'd5);
        send_request(KIND_INSERT, 31'd5);
        send_request(KIND_INSERT, 31'd5);
        send_request(KIND_FIND, 31'd5);
        send_request(KIND_SPARE, 31'd5);
        send_request(KIND_INSERT, 31'd16);   // same home slot as 5 with size 11
        send_request(KIND_DELETE, 31'd5);
        send_request(KIND_DELETE, 31'd5);
        send_request(KIND_FIND, 31'd5);
        send_request(KIND_INSERT, 31'd5);    // reuses the deleted slot
        send_request(KIND_INSERT, 31'd0);
        send_request(KIND_DELETE, 31'd0);
        send_request(KIND_INSERT, 31'h7FFF_FFFF);
        send_request(KIND_FIND, 31'h7FFF_FFFF);
        send_request(KIND_DELETE, 31'h2AAA_AAAA);
        send_request(KIND_INSERT, 31'h5555_5555);
        send_request(KIND_INSERT, 31'd1);
    endtask

    // fill the small table until probing runs out
    task automatic test_full_table();
        for (int i = 0; i < 24; i++)
            send_request(KIND_INSERT, KEY_W'(100 + i * 7));
        send_request(KIND_FIND, 31'd999);
        send_request(KIND_DELETE, 31'd999);
    endtask

    // long receiver hold so the input stalls, then a full pause
    task automatic test_backpressure();
        fork
            begin
                hold_receiver = 1;
                repeat (400) @(negedge clk);
                hold_receiver = 0;
            end
            for (int i = 0; i < 6; i++)
                send_request(2'($urandom_range(0, 2)), random_key(1));
        join
        drain();
    endtask

    task automatic test_random(input int count, input int unsigned size);
        logic [1:0] kind;
        set_table_size(size);
        for (int i = 0; i < count; i++)
        begin
            kind = ($urandom_range(0, 19) == 0) ? KIND_SPARE : 2'($urandom_range(0, 2));
            send_request(kind, ($urandom_range(0, 49) == 0) ? 31'd0 : random_key(size));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        error_count = 0;
        result_count = 0;
        cycle_count = 0;
        idle_enable = 1;
        hold_receiver = 0;
        active_size = SIZE_RESET;
        for (int i = 0; i < SLOT_CAPACITY; i++)
        begin
            slot_state[i] = SLOT_EMPTY;
            key_store[i] = '0;
        end
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_full_table();
        test_backpressure();
        test_random(300, 1021);
        test_random(300, 13);
        test_random(300, 257);
        test_random(400, 11);
        test_random(300, 1021);
        idle_enable = 0;
        test_random(400, 1021);
        drain();

        $display("covered %0d results over table sizes 11..1021, including full tables,",
                 result_count);
        $display("lazy deletes, zero keys and stalls on both streams");
        if (error_count == 0)
            $display("open_addressing_hash_table_core: match");
        else
            $display("open_addressing_hash_table_core: mismatch");
        $finish;
    end

endmodule

// File: files.f
rtl/core/oaht_pkg.sv
rtl/core/oaht_ram.sv
rtl/core/open_addressing_hash_table_core.sv
dv/open_addressing_hash_table_core_test.sv
